FILE: rtl/bitmap_text_column_generator_macros.svh
// Assertion macros for the bitmap text column generator.
// Used by the RTL modules; the macros expect signals named clk and rst_n in scope.
`ifndef BITMAP_TEXT_COLUMN_GENERATOR_MACROS_SVH
`define BITMAP_TEXT_COLUMN_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising edge of clk outside reset.
`define BTCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every rising edge of clk, reset included.
`define BTCG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BTCG_ASSERT(lbl, prop, msg)
`define BTCG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/btcg_pkg.sv
// Shared types and constants for the bitmap text column generator.
// No dependencies; imported by every RTL module of the block.
package btcg_pkg;

  localparam int FONT_CHARS    = 256;
  localparam int GLYPH_COLUMNS = 5;
  localparam int SLANT_DEPTH   = 7;
  localparam int STORE_SIZE    = FONT_CHARS * GLYPH_COLUMNS;
  localparam int ADDR_W        = 11;
  localparam int FIFO_DEPTH    = 4;
  localparam int STEP_W        = 4;
  localparam int COL_W         = 3;

  localparam logic [STEP_W-1:0] LAST_STEP_SINGLE = STEP_W'(GLYPH_COLUMNS);
  localparam logic [STEP_W-1:0] LAST_STEP_DOUBLE = STEP_W'(2 * GLYPH_COLUMNS + 1);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] CMD_GRAPHICS = 8'd8;
  localparam logic [7:0] CMD_TEXT     = 8'd15;
  localparam logic [7:0] CMD_RETURN   = 8'd13;

  localparam logic [6:0] UNDERLINE_DOT = 7'h40;
  localparam logic [6:0] INVERSE_MASK  = 7'h7F;
  localparam logic [6:0] SLANT_TOP_DOT = 7'h40;
  localparam logic [6:0] SLANT_LOW_DOT = 7'h01;

  localparam int STY_UNDERLINE = 0;
  localparam int STY_INVERSE   = 1;
  localparam int STY_ITALIC    = 2;
  localparam int STY_DOUBLE    = 3;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BEGIN = 2'd1,
    ACT_PRINT = 2'd2,
    ACT_END   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_END,
    ST_NEWLINE,
    ST_CHAR
  } state_t;

  typedef enum logic [1:0] {
    OP_CMD,
    OP_COL,
    OP_REP
  } op_kind_t;

  // One output operation handed from the sequencer to the column unit.
  typedef struct packed {
    logic       valid;
    op_kind_t   kind;
    logic [7:0] cmd;
    logic       last;
    logic       clear;
    logic       blank;
  } op_t;

endpackage

FILE: rtl/btcg_font_ram.sv
// Font store: single-port-write, single-port-read synchronous RAM.
// Depends on btcg_pkg for the store size and address width.
module btcg_font_ram
  import btcg_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [0:STORE_SIZE-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/btcg_col_unit.sv
// Column unit: applies the print style to font columns and runs the slant stages.
// Depends on btcg_pkg and the assertion macro header.
`include "bitmap_text_column_generator_macros.svh"
module btcg_col_unit
  import btcg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  op_t        op_in,
  input  logic [7:0] font_data,
  input  logic [3:0] style,
  output logic       s1_valid,
  output logic       push_valid,
  output logic [7:0] push_byte,
  output logic       push_last
);

  op_t                               s1_op_r;
  logic                              s1_valid_r;
  logic [SLANT_DEPTH-1:0][6:0]       slant_r;
  logic [SLANT_DEPTH-1:0][6:0]       slant_nxt;
  logic [7:0]                        hold_r;
  logic [6:0]                        col;
  logic [6:0]                        styled;
  logic [6:0]                        shaped;
  logic [7:0]                        byte_out;

  always_comb begin
    col = s1_op_r.blank ? 7'd0 : font_data[7:1];
    styled = col;
    if (style[STY_UNDERLINE]) begin
      styled = styled | UNDERLINE_DOT;
    end
    if (style[STY_INVERSE]) begin
      styled = styled ^ INVERSE_MASK;
    end
    for (int s = 0; s < SLANT_DEPTH - 1; s++) begin
      slant_nxt[s] = (styled & (SLANT_TOP_DOT >> s)) | slant_r[s+1];
    end
    slant_nxt[SLANT_DEPTH-1] = styled & SLANT_LOW_DOT;
    shaped = style[STY_ITALIC] ? slant_nxt[0] : styled;
  end

  always_comb begin
    case (s1_op_r.kind)
      OP_CMD:  byte_out = s1_op_r.cmd;
      OP_COL:  byte_out = {1'b1, shaped};
      OP_REP:  byte_out = hold_r;
      default: byte_out = s1_op_r.cmd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      slant_r    <= '0;
    end else begin
      s1_valid_r <= op_in.valid;
      if (s1_valid_r && s1_op_r.kind == OP_CMD && s1_op_r.clear) begin
        slant_r <= '0;
      end else if (s1_valid_r && s1_op_r.kind == OP_COL && style[STY_ITALIC]) begin
        slant_r <= slant_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r <= op_in;
    if (s1_valid_r && s1_op_r.kind == OP_COL) begin
      hold_r <= {1'b1, shaped};
    end
  end

  assign s1_valid   = s1_valid_r;
  assign push_valid = s1_valid_r;
  assign push_byte  = byte_out;
  assign push_last  = s1_op_r.last;

  `BTCG_ASSERT(a_slant_cleared, (s1_valid_r && s1_op_r.kind == OP_CMD && s1_op_r.clear) |=> (slant_r == '0), "slant stages not cleared after begin or newline")
  `BTCG_ASSERT(a_slant_kept, (s1_valid_r && !style[STY_ITALIC] && s1_op_r.kind != OP_CMD) |=> $stable(slant_r), "slant stages changed with italic off")

endmodule

FILE: rtl/btcg_out_fifo.sv
// Output queue: a small register FIFO that decouples the column unit from the result port.
// Depends on btcg_pkg and the assertion macro header.
`include "bitmap_text_column_generator_macros.svh"
module btcg_out_fifo
  import btcg_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  logic [7:0]                      push_byte,
  input  logic                            push_last,
  output logic [$clog2(FIFO_DEPTH+1)-1:0] count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_last
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [8:0]       buf_r [0:FIFO_DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_byte  = buf_r[rd_ptr_r][7:0];
  assign out_last  = buf_r[rd_ptr_r][8];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= {push_last, push_byte};
    end
  end

  `BTCG_ASSERT(a_no_overflow, (push && !pop) |-> (count_r != CNT_W'(FIFO_DEPTH)), "output queue overflow")

endmodule

FILE: rtl/bitmap_text_column_generator.sv
// Top level of the bitmap text column generator: item sequencer and port wiring.
// Depends on btcg_pkg, btcg_font_ram, btcg_col_unit, btcg_out_fifo and the macro header.
//
//   Channel   Direction  Ports                         Payload
//   in_       slave      in_tvalid/in_tready           tuser: action; tdata: addr, byte, code
//   out_      master     out_tvalid/out_tready         tdata: frame_byte; tlast: last
//   cfg_      write      cfg_wr_en                     cfg_wr_data: print_style
//
// A printed character produces six column bytes, or twelve with double width, one per
// cycle while the output queue has room; the font store is read only for each new
// non-blank column; the result port drains one byte per cycle while out_tready is high.
// Begin and end produce one byte each, newline three, and a font load none.
// The next item is taken in the cycle that issues the last byte of the current one.
// Reset (synchronous, active low) clears the sequencer, the slant stages, the style and
// the output queue; the font store is not cleared and needs no clearing pass.
// When out_tready is low, up to four bytes collect in the output queue before the
// sequencer holds, and in_tready then stays low until the held item finishes issuing.
`include "bitmap_text_column_generator_macros.svh"
module bitmap_text_column_generator
  import btcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [10:0] font_addr, [18:11] font_byte, [26:19] char_code
  input  logic [1:0]  in_tuser,   // [1:0] action
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] frame_byte
  output logic        out_tlast,
  // Configuration register.
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data // [3:0] print_style
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [7:0]          code_r;
  logic [3:0]          style_r;

  action_t             in_action;
  logic [ADDR_W-1:0]   in_font_addr;
  logic [7:0]          in_font_byte;
  logic [7:0]          in_char_code;
  logic                accept;

  op_t                 op;
  logic                last_op;
  logic                issue;
  logic                room;
  logic                dbl;
  logic [COL_W-1:0]    col;
  logic                code_oob;
  logic [ADDR_W-1:0]   rd_addr;
  logic                ram_we;
  logic                ram_re;
  logic [7:0]          font_data;

  logic                s1_valid;
  logic                push_valid;
  logic [7:0]          push_byte;
  logic                push_last;
  logic [CNT_W-1:0]    fifo_count;

  // Unpack the input transfer.
  assign in_action    = action_t'(in_tuser);
  assign in_font_addr = in_tdata[10:0];
  assign in_font_byte = in_tdata[18:11];
  assign in_char_code = in_tdata[26:19];

  // An operation may only be issued when the queue can take it together with the one
  // already in the column unit.
  assign room   = (CNT_W'(fifo_count) + CNT_W'(s1_valid) + CNT_W'(1)) <= CNT_W'(FIFO_DEPTH);
  assign issue  = (state_r != ST_IDLE) && room;
  assign dbl    = style_r[STY_DOUBLE];

  assign in_tready = (state_r == ST_IDLE) || (issue && last_op);
  assign accept    = in_tvalid && in_tready;

  // Font loads go straight into the store; addresses past its end are dropped.
  assign ram_we = accept && (in_action == ACT_LOAD) && (in_font_addr < ADDR_W'(STORE_SIZE));

  // Column index and store address of the current character column.
  assign col      = dbl ? step_r[COL_W:1] : step_r[COL_W-1:0];
  assign code_oob = ({1'b0, code_r} >= 9'(FONT_CHARS));
  assign rd_addr  = (ADDR_W'(code_r) << 2) + ADDR_W'(code_r) + ADDR_W'(col);
  assign ram_re   = issue && (op.kind == OP_COL) && !op.blank;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    if (accept) begin
      step_nxt = '0;
      case (in_action)
        ACT_LOAD:  state_nxt = ST_IDLE;
        ACT_BEGIN: state_nxt = ST_BEGIN;
        ACT_END:   state_nxt = ST_END;
        ACT_PRINT: state_nxt = (in_char_code == NEWLINE_CODE) ? ST_NEWLINE : ST_CHAR;
        default:   state_nxt = ST_IDLE;
      endcase
    end else if (issue) begin
      if (last_op) begin
        state_nxt = ST_IDLE;
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
  end

  // Operation issued by the sequencer in its current state.
  always_comb begin
    op       = '0;
    op.kind  = OP_CMD;
    op.valid = issue;
    last_op  = 1'b0;
    case (state_r)
      ST_BEGIN: begin
        op.cmd   = CMD_GRAPHICS;
        op.clear = 1'b1;
        last_op  = 1'b1;
      end
      ST_END: begin
        op.cmd  = CMD_TEXT;
        last_op = 1'b1;
      end
      ST_NEWLINE: begin
        case (step_r)
          STEP_W'(0): op.cmd = CMD_TEXT;
          STEP_W'(1): op.cmd = CMD_RETURN;
          default: begin
            op.cmd   = CMD_GRAPHICS;
            op.clear = 1'b1;
            last_op  = 1'b1;
          end
        endcase
      end
      ST_CHAR: begin
        // With double width every odd step repeats the column just styled.
        op.kind  = (dbl && step_r[0]) ? OP_REP : OP_COL;
        op.blank = (col == COL_W'(GLYPH_COLUMNS)) || code_oob;
        last_op  = (step_r == (dbl ? LAST_STEP_DOUBLE : LAST_STEP_SINGLE));
      end
      default: begin
        last_op = 1'b0;
      end
    endcase
    op.last = last_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      style_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_wr_en) begin
        style_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      code_r <= in_char_code;
    end
  end

  btcg_font_ram u_font_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (in_font_addr),
    .wr_data (in_font_byte),
    .rd_en   (ram_re),
    .rd_addr (rd_addr),
    .rd_data (font_data)
  );

  btcg_col_unit u_col_unit (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_in      (op),
    .font_data  (font_data),
    .style      (style_r),
    .s1_valid   (s1_valid),
    .push_valid (push_valid),
    .push_byte  (push_byte),
    .push_last  (push_last)
  );

  btcg_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_byte (push_byte),
    .push_last (push_last),
    .count     (fifo_count),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

  // A font write may only meet a pending read stream when that stream is ending.
  `BTCG_ASSERT(a_load_after_reads, (ram_we && issue) |-> last_op, "font load overlaps a character still being read")
  // The sequencer never issues while idle.
  `BTCG_ASSERT(a_idle_quiet, (state_r == ST_IDLE) |=> ((state_r != ST_IDLE) || !s1_valid), "operation issued from idle")

endmodule
